### sv/sorted_table_lower_bound_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table lower-bound search unit
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_LOWER_BOUND_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_LOWER_BOUND_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define STLB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("stlb: invariant violated");

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define STLB_ASSERT_IMPLY(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error("stlb: implication violated");

`else

`define STLB_ASSERT_ALWAYS(label, cond)
`define STLB_ASSERT_IMPLY(label, trig, cons)

`endif

`endif

### sv/stlb_pkg.sv
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared constants and types of the sorted table lower-bound search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stlb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 11;
    localparam int INDEX_W     = 10;

    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 16;

    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_PROBE,
        ST_FINAL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
        logic             found;
    } result_t;

endpackage

### sv/stlb_ram.sv
// ----------------------------------------------------------------------------
// stlb_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/stlb_seq.sv
// ----------------------------------------------------------------------------
// stlb_seq
// Search sequencer: boundary checks, then a bisection that issues one table
// read per cycle and feeds every read word through one shared comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_table_lower_bound_search_unit_assert.svh"

module stlb_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [stlb_pkg::KEY_W-1:0]     key,
    input  logic [stlb_pkg::POS_W-1:0]     table_size,
    output logic                           ready,
    output logic [stlb_pkg::ADDR_W-1:0]    rd_addr,
    input  logic [stlb_pkg::KEY_W-1:0]     rd_data,
    output stlb_pkg::result_t              result,
    input  logic                           result_ready
);

    stlb_pkg::state_t state_reg, state_next;

    logic [stlb_pkg::KEY_W-1:0] key_reg;
    logic [stlb_pkg::POS_W-1:0] n_reg, n_next;
    logic [stlb_pkg::POS_W-1:0] lo_reg, lo_next;
    logic [stlb_pkg::POS_W-1:0] hi_reg, hi_next;
    logic [stlb_pkg::POS_W-1:0] mid_reg, mid_next;
    logic [stlb_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       found_reg, found_next;

    logic                       key_gt;
    logic                       key_eq;
    logic [stlb_pkg::POS_W-1:0] n_clamp;
    logic [stlb_pkg::POS_W-1:0] probe_lo;
    logic [stlb_pkg::POS_W-1:0] probe_hi;
    logic [stlb_pkg::POS_W:0]   probe_sum;
    logic [stlb_pkg::POS_W-1:0] probe_mid;
    logic                       probe_more;
    logic                       first_more;

    // The shared compare unit: key against the word read last cycle.
    assign key_gt = key_reg > rd_data;
    assign key_eq = key_reg == rd_data;

    assign n_clamp = (table_size > stlb_pkg::DEPTH_POS) ? stlb_pkg::DEPTH_POS : table_size;

    // One bisection step: narrow the window, then pick the next probe point.
    always_comb begin
        probe_lo   = key_gt ? mid_reg : lo_reg;
        probe_hi   = key_gt ? hi_reg : mid_reg + stlb_pkg::POS_W'(1);
        probe_sum  = {1'b0, probe_lo} + {1'b0, probe_hi};
        probe_mid  = probe_sum[stlb_pkg::POS_W:1];
        probe_more = (probe_hi - probe_lo) > stlb_pkg::POS_W'(2);
    end

    // The first window is [0, n); its midpoint is also the final point when
    // the window is already narrow.
    assign first_more = n_reg > stlb_pkg::POS_W'(2);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stlb_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = (n_clamp == '0) ? stlb_pkg::ST_RESP : stlb_pkg::ST_FIRST;
                end
            end
            stlb_pkg::ST_FIRST: begin
                state_next = key_gt ? stlb_pkg::ST_LAST : stlb_pkg::ST_RESP;
            end
            stlb_pkg::ST_LAST: begin
                if (key_gt) begin
                    state_next = stlb_pkg::ST_RESP;
                end else begin
                    state_next = first_more ? stlb_pkg::ST_PROBE : stlb_pkg::ST_FINAL;
                end
            end
            stlb_pkg::ST_PROBE: begin
                state_next = probe_more ? stlb_pkg::ST_PROBE : stlb_pkg::ST_FINAL;
            end
            stlb_pkg::ST_FINAL: begin
                state_next = stlb_pkg::ST_RESP;
            end
            stlb_pkg::ST_RESP: begin
                if (result_ready) begin
                    state_next = stlb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stlb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_next     = n_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = '0;
        pos_next   = pos_reg;
        found_next = found_reg;
        case (state_reg)
            stlb_pkg::ST_IDLE: begin
                n_next     = n_clamp;
                pos_next   = '0;
                found_next = 1'b0;
            end
            stlb_pkg::ST_FIRST: begin
                mid_next   = n_reg - stlb_pkg::POS_W'(1);
                pos_next   = '0;
                found_next = key_eq;
            end
            stlb_pkg::ST_LAST: begin
                lo_next    = '0;
                hi_next    = n_reg;
                mid_next   = {1'b0, n_reg[stlb_pkg::POS_W-1:1]};
                pos_next   = n_reg;
                found_next = 1'b0;
            end
            stlb_pkg::ST_PROBE: begin
                lo_next  = probe_lo;
                hi_next  = probe_hi;
                mid_next = probe_mid;
            end
            stlb_pkg::ST_FINAL: begin
                pos_next   = mid_reg;
                found_next = key_eq;
            end
            stlb_pkg::ST_RESP: begin
                mid_next = '0;
            end
            default: begin
                mid_next = '0;
            end
        endcase
    end

    always_comb begin
        ready           = state_reg == stlb_pkg::ST_IDLE;
        rd_addr         = mid_next[stlb_pkg::ADDR_W-1:0];
        result.valid    = state_reg == stlb_pkg::ST_RESP;
        result.position = pos_reg;
        result.found    = found_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stlb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
        end
        n_reg     <= n_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
    end

    `STLB_ASSERT_IMPLY(a_start_when_idle, start, state_reg == stlb_pkg::ST_IDLE)
    `STLB_ASSERT_IMPLY(a_probe_window, state_reg == stlb_pkg::ST_PROBE,
        (hi_reg > lo_reg) && ((hi_reg - lo_reg) > stlb_pkg::POS_W'(2)))
    `STLB_ASSERT_IMPLY(a_read_in_table,
        (state_reg == stlb_pkg::ST_FIRST) || (state_reg == stlb_pkg::ST_LAST) ||
        (state_reg == stlb_pkg::ST_PROBE) || (state_reg == stlb_pkg::ST_FINAL),
        mid_reg < n_reg)
    `STLB_ASSERT_IMPLY(a_result_bounded, result.valid,
        (result.position <= n_reg) && (!result.found || (result.position < n_reg)))

endmodule

### sv/sorted_table_lower_bound_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search_unit
// Table of sorted keys with a lower-bound search by bisection.
// ----------------------------------------------------------------------------
// A write transfer (tuser 0) stores one key in the table RAM and gives no
// result. A search transfer (tuser 1) reads entry 0, then the last entry in
// use, then bisects the table, one RAM read per cycle through one comparator,
// and ends with one more read for the found flag; it stops early when the
// table is empty, the key is at most entry 0, or above the last entry. The
// table RAM's single read port sets the pace: a search holds s_tready low
// until its result has been taken on m_tready. table_size must be written
// only while the unit is idle; values above 1024 act as 1024.
`timescale 1ns / 1ps

module sorted_table_lower_bound_search_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: table_size
    input  logic                             cfg_wr_en,
    input  logic [stlb_pkg::POS_W-1:0]       cfg_wr_data,
    // Input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stlb_pkg::S_TDATA_W-1:0]   s_tdata,   // entry_index[9:0], key_value[73:10]
    input  logic [0:0]                       s_tuser,   // operation[0]
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stlb_pkg::M_TDATA_W-1:0]   m_tdata    // position[10:0], found[11]
);

    logic [stlb_pkg::POS_W-1:0]   table_size_reg;
    logic [stlb_pkg::INDEX_W-1:0] entry_index;
    logic [stlb_pkg::KEY_W-1:0]   key_value;
    logic                         in_xfer;
    logic                         is_search;
    logic                         wr_en;
    logic [stlb_pkg::ADDR_W-1:0]  rd_addr;
    logic [stlb_pkg::KEY_W-1:0]   rd_data;
    stlb_pkg::result_t            result;

    assign entry_index = s_tdata[stlb_pkg::INDEX_W-1:0];
    assign key_value   = s_tdata[stlb_pkg::INDEX_W +: stlb_pkg::KEY_W];
    assign in_xfer     = s_tvalid && s_tready;
    assign is_search   = s_tuser[0] == stlb_pkg::OP_SEARCH;

    // Writes to slots beyond the table depth are dropped.
    assign wr_en = in_xfer && !is_search &&
                   (stlb_pkg::POS_W'(entry_index) < stlb_pkg::DEPTH_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= '0;
        end else if (cfg_wr_en) begin
            table_size_reg <= cfg_wr_data;
        end
    end

    stlb_ram #(
        .WIDTH (stlb_pkg::KEY_W),
        .DEPTH (stlb_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (entry_index[stlb_pkg::ADDR_W-1:0]),
        .wr_data (key_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stlb_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (in_xfer && is_search),
        .key          (key_value),
        .table_size   (table_size_reg),
        .ready        (s_tready),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result       (result),
        .result_ready (m_tready)
    );

    assign m_tvalid = result.valid;
    assign m_tdata  = {
        (stlb_pkg::M_TDATA_W - stlb_pkg::POS_W - 1)'(0),
        result.found,
        result.position
    };

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted table lower-bound search unit.
// Loads tables of 64-bit keys and drives searches through the stream ports.
// A local table copy and a bisection predictor give the expected position
// and found flag of each untyped search. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import stlb_pkg::*;

    localparam int          CLK_PERIOD    = 4;
    localparam int          RESET_CYCLES  = 5;
    localparam int          TOTAL_ITEMS   = 1700;
    localparam int          DRAIN_CYCLES  = 24;
    localparam int          LONG_HOLD     = 600;
    localparam int          HOLD_AFTER    = 150;
    localparam int          REPORT_LIMIT  = 10;
    localparam longint      RUN_LIMIT_NS  = 64'd20_000_000;
    localparam logic [63:0] KEY_MAX       = '1;
    localparam logic [63:0] KEY_TOP_BIT   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_BELOW_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } search_result_t;

    // A row either writes table_size or sends one item. Rows with a typed
    // answer bypass the predictor.
    typedef struct packed {
        logic               is_cfg;
        logic [POS_W-1:0]   size;
        op_t                op;
        logic [INDEX_W-1:0] idx;
        logic [KEY_W-1:0]   key;
        logic               typed;
        logic [POS_W-1:0]   pos;
        logic               hit;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 24;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd0,                  1'b1, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    KEY_MAX,                1'b1, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd0,    64'd0,                  1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd1,    64'd100,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd2,    64'd200,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd3,    64'd300,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd4,    KEY_MAX,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd1023, KEY_MAX,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd512,  64'h5555_5555_5555_5555, 1'b0, 11'd0, 1'b0},
        '{1'b1, 11'd5, OP_WRITE,  10'd0,    64'd0,                  1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd0,                  1'b1, 11'd0, 1'b1},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd150,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd300,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd301,                1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd1023, KEY_MAX,                1'b0, 11'd0, 1'b0},
        '{1'b1, 11'd1, OP_WRITE,  10'd0,    64'd0,                  1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd0,                  1'b1, 11'd0, 1'b1},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    64'd7,                  1'b1, 11'd1, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    KEY_MAX,                1'b1, 11'd1, 1'b0},
        '{1'b0, 11'd0, OP_WRITE,  10'd0,    KEY_TOP_BIT,            1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    KEY_TOP_BIT,            1'b1, 11'd0, 1'b1},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    KEY_BELOW_TOP,          1'b1, 11'd0, 1'b0},
        '{1'b1, 11'd0, OP_WRITE,  10'd0,    64'd0,                  1'b0, 11'd0, 1'b0},
        '{1'b0, 11'd0, OP_SEARCH, 10'd0,    KEY_TOP_BIT,            1'b1, 11'd0, 1'b0}
    };

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [POS_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic [0:0]             s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Local copy of the table and of table_size, updated at each transfer.
    logic [KEY_W-1:0]       model_table [TABLE_DEPTH];
    logic [POS_W-1:0]       model_size;
    search_result_t         pending_results [$];
    search_result_t         got_res;
    search_result_t         want_res;
    int unsigned            items_accepted;
    int unsigned            results_seen;
    int unsigned            mismatch_count;
    bit                     sender_burst;
    bit                     long_hold_done;

    sorted_table_lower_bound_search_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // entry_index[9:0], key_value[73:10]
        .s_tuser     (s_tuser),   // operation[0]
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)    // position[10:0], found[11]
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Lower bound by the unit's own bisection, which also fixes the answer
    // for a table that is not sorted.
    function automatic search_result_t predict_lower_bound(input logic [KEY_W-1:0] key);
        int unsigned    n;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        search_result_t r;
        r = '0;
        n = (model_size > DEPTH_POS) ? TABLE_DEPTH : model_size;
        if (n == 0) return r;
        if (key <= model_table[0]) begin
            r.found = (key == model_table[0]);
            return r;
        end
        if (key > model_table[n-1]) begin
            r.position = POS_W'(n);
            return r;
        end
        lo  = 0;
        hi  = n;
        mid = lo + (hi - lo) / 2;
        while (hi - lo > 2) begin
            if (key > model_table[mid]) lo = mid;
            else hi = mid + 1;
            mid = lo + (hi - lo) / 2;
        end
        r.position = POS_W'(mid);
        r.found    = (model_table[mid] == key);
        return r;
    endfunction

    // Offers one item and returns at the edge where it is transferred.
    task automatic transfer_item(input op_t op, input logic [INDEX_W-1:0] idx,
                                 input logic [KEY_W-1:0] key, input logic typed,
                                 input search_result_t typed_res);
        int unsigned gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - KEY_W - INDEX_W){1'b0}}, key, idx};
        do @(posedge aclk); while (!s_tready);
        items_accepted++;
        if (op == OP_WRITE) model_table[idx] = key;
        else if (typed) pending_results.push_back(typed_res);
        else pending_results.push_back(predict_lower_bound(key));
    endtask

    // table_size changes only once every search has answered and the unit
    // has had time to settle.
    task automatic write_table_size(input logic [POS_W-1:0] n);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        model_size = n;
        cfg_wr_en <= 1'b0;
    endtask

    // Writes entries 0 to n-1, sorted with repeats unless scrambled.
    task automatic load_table(input int unsigned n, input bit scrambled);
        logic [KEY_W-1:0] keys [$];
        int unsigned      i;
        for (i = 0; i < n; i++) keys.push_back(random_key());
        if (!scrambled && n != 0) begin
            keys.sort();
            for (i = 1; i < n; i++)
                if ($urandom_range(0, 4) == 0) keys[i] = keys[i-1];
            if ($urandom_range(0, 3) == 0) keys[0] = '0;
            if ($urandom_range(0, 3) == 0) keys[n-1] = KEY_MAX;
        end
        for (i = 0; i < n; i++)
            transfer_item(OP_WRITE, INDEX_W'(i), keys[i], 1'b0, '0);
    endtask

    // Keys near table contents hit the equality and boundary paths.
    function automatic logic [KEY_W-1:0] pick_search_key();
        int unsigned n;
        int unsigned j;
        int unsigned sel;
        n = (model_size > DEPTH_POS) ? TABLE_DEPTH : model_size;
        if (n == 0) return random_key();
        j   = $urandom_range(0, n - 1);
        sel = $urandom_range(0, 19);
        if (sel < 9)   return model_table[j];
        if (sel < 11)  return model_table[j] + 64'd1;
        if (sel < 13)  return model_table[j] - 64'd1;
        if (sel == 13) return '0;
        if (sel == 14) return KEY_MAX;
        if (sel == 15) return model_table[0] - 64'd1;
        if (sel == 16) return model_table[n-1] + 64'd1;
        return random_key();
    endfunction

    // Searches with a few stray writes to any slot mixed in.
    task automatic run_searches(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0)
                transfer_item(OP_WRITE, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                              random_key(), 1'b0, '0);
            else
                transfer_item(OP_SEARCH, INDEX_W'($urandom), pick_search_key(), 1'b0, '0);
        end
    endtask

    task automatic run_small_phase();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 9);
        if (kind < 3) n = kind;
        else n = $urandom_range(3, 48);
        load_table(n, $urandom_range(0, 5) == 0);
        write_table_size(POS_W'(n));
        run_searches($urandom_range(20, 40));
    endtask

    // The one full-depth table, searched at 1024 and at oversized sizes.
    task automatic run_full_phase();
        load_table(TABLE_DEPTH, 1'b0);
        write_table_size(DEPTH_POS);
        run_searches(60);
        write_table_size('1);
        run_searches(30);
        write_table_size(POS_W'($urandom_range(TABLE_DEPTH + 1, 2046)));
        run_searches(20);
    endtask

    task automatic note_mismatch(input string what, input search_result_t want,
                                 input search_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected position %0d found %0d, got position %0d found %0d",
                     $realtime, what, want.position, want.found, got.position, got.found);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got_res.position = m_tdata[POS_W-1:0];
            got_res.found    = m_tdata[POS_W];
            if (pending_results.size() == 0) begin
                note_mismatch("result with no search pending", '0, got_res);
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.position != want_res.position)
                    note_mismatch("position mismatch", want_res, got_res);
                if (got_res.found != want_res.found)
                    note_mismatch("found flag mismatch", want_res, got_res);
            end
        end
    end

    // Result side: random stalls, and once a long hold-off so that the unit
    // backs up into its input.
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = pick_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12)) @(posedge aclk);
        end
    end

    initial begin
        int unsigned   row;
        int unsigned   phase;
        directed_row_t r;
        search_result_t typed_res;
        for (row = 0; row < TABLE_DEPTH; row++) model_table[row] = '0;
        model_size     = '0;
        items_accepted = 0;
        results_seen   = 0;
        mismatch_count = 0;
        sender_burst   = 1'b0;
        long_hold_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIRECTED_COUNT; row++) begin
            r = DIRECTED_ROWS[row];
            typed_res.position = r.pos;
            typed_res.found    = r.hit;
            if (r.is_cfg) write_table_size(r.size);
            else transfer_item(r.op, r.idx, r.key, r.typed, typed_res);
        end

        phase = 0;
        while (items_accepted < TOTAL_ITEMS) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            if (phase == 2) run_full_phase();
            else run_small_phase();
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
